### rtl/pfdc_pkg.sv
// Shared types and constants for the pulse-frequency to DAC-code block.
// Used by pfdc_div, pulse_frequency_to_dac_code and the testbench.
`default_nettype none
package pfdc_pkg;

  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam int FREQ_W = 20;
  localparam int CODE_W = 12;
  localparam int MV_W   = 13;
  localparam int PW_W   = 32;
  localparam int TS_W   = 32;

  // serial divider: fixed quotient width and its step counter
  localparam int QUO_W = 20;
  localparam int CNT_W = $clog2(QUO_W + 1);

  localparam int FREQ_SCALE = 1000000;
  localparam int F_LO       = 50;
  localparam int F_HI       = 150;
  localparam int F_SPAN     = 100;
  localparam int CODE_FULL  = 4095;
  localparam int CODE_LO_N  = 410;
  localparam int CODE_HI_N  = 3700;
  localparam int MV_FULL    = 4950;

  // shared multiplier; the divides by F_SPAN and CODE_FULL are done as
  // (x * RECIP) >> SH, exact for x up to 99*4095 and below 2^25 respectively
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 26;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int RECIP_SPAN = 335545;
  localparam int SH_SPAN    = 25;
  localparam int RECIP_FULL = 33562627;
  localparam int SH_FULL    = 37;

  typedef struct packed {
    logic            command;
    logic [TS_W-1:0] timestamp_us;
    logic            edge_falling;
  } in_beat_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency_hz;
    logic [PW_W-1:0]   pulse_width_us;
    logic [CODE_W-1:0] dac_code;
    logic [MV_W-1:0]   output_millivolts;
    logic              sample_valid;
  } out_beat_t;

endpackage
`default_nettype wire

### rtl/pfdc_div.sv
// Restoring divider, one quotient bit per cycle, fixed 20-bit quotient.
// Requires num < den * 2^20. Uses pfdc_pkg.
`default_nettype none
module pfdc_div #(
  parameter int TIME_BITS = 32,
  parameter int NUM_W     = 33
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [NUM_W-1:0]            num,
  input  wire logic [TIME_BITS-1:0]        den,
  output logic                             done,
  output logic [pfdc_pkg::QUO_W-1:0]       quo
);

  logic [TIME_BITS-1:0]         rem;
  logic [TIME_BITS-1:0]         den_r;
  logic [pfdc_pkg::QUO_W-1:0]   quo_sh;
  logic [pfdc_pkg::CNT_W-1:0]   cnt;
  logic [TIME_BITS:0]           sh;
  logic [TIME_BITS+1:0]         diff;
  logic                         ge;

  // remainder stays below den, so it fits TIME_BITS
  assign sh   = {rem, quo_sh[pfdc_pkg::QUO_W-1]};
  assign diff = {1'b0, sh} - {2'b00, den_r};
  assign ge   = ~diff[TIME_BITS+1];
  assign quo  = quo_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= pfdc_pkg::CNT_W'(pfdc_pkg::QUO_W);
      end else if (cnt != '0) begin
        cnt <= cnt - pfdc_pkg::CNT_W'(1);
        if (cnt == pfdc_pkg::CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= TIME_BITS'(num[NUM_W-1:pfdc_pkg::QUO_W]);
      quo_sh <= num[pfdc_pkg::QUO_W-1:0];
      den_r  <= den;
    end else if (cnt != '0) begin
      rem    <= ge ? diff[TIME_BITS-1:0] : sh[TIME_BITS-1:0];
      quo_sh <= {quo_sh[pfdc_pkg::QUO_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### rtl/pfdc_track.sv
// Edge tracker: arming, phase toggle, mark/rise times and period.
// Depends on nothing but its ports.
`default_nettype none
module pfdc_track #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 edge_ev,
  input  wire logic [TIME_BITS-1:0] ts,
  input  wire logic                 falling,
  output logic [TIME_BITS-1:0]      period,
  output logic [TIME_BITS-1:0]      width
);

  logic                 armed;
  logic                 edge_phase;
  logic [TIME_BITS-1:0] latest_rise;
  logic [TIME_BITS-1:0] mark_time;

  assign width = mark_time - latest_rise;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      edge_phase  <= 1'b0;
      latest_rise <= '0;
      mark_time   <= '0;
      period      <= '0;
    end else if (edge_ev) begin
      if (!armed) begin
        armed <= falling;
      end else if (edge_phase) begin
        // rise phase: period spans from the previous rise
        edge_phase  <= 1'b0;
        latest_rise <= ts;
        period      <= ts - latest_rise;
      end else begin
        edge_phase <= 1'b1;
        mark_time  <= ts;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/pulse_frequency_to_dac_code.sv
// Pulse-frequency to DAC-code converter.
// Edge beat: updates the edge tracker, no result. Sample beat: the divider finds
// the frequency, then shared-multiplier steps find code and mV (no code step when
// the frequency lies outside 51..149 Hz), and out_valid rises once they are done.
// Next beat is taken in the same cycle as out_valid rises, later while the result is
// stalled. Sync reset clears tracker, sequencer and out_valid; mode resets to 1.
`default_nettype none
module pulse_frequency_to_dac_code #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic                cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pfdc_pkg::in_beat_t  in_beat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pfdc_pkg::out_beat_t      out_beat
);

  localparam int NUM_W = ((TIME_BITS > 25) ? TIME_BITS : 25) + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FREQ = 6'b000010,
    ST_MAP  = 6'b000100,
    ST_CODE = 6'b001000,
    ST_MVM  = 6'b010000,
    ST_MV   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   st_done;

  logic                          mode;
  logic [TIME_BITS-1:0]          ts;
  logic [TIME_BITS-1:0]          period;
  logic [TIME_BITS-1:0]          width;
  logic                          edge_ev;
  logic                          sample_ev;

  logic                          div_start;
  logic [NUM_W-1:0]              div_num;
  logic [TIME_BITS-1:0]          div_den;
  logic                          div_done;
  logic [pfdc_pkg::QUO_W-1:0]    quo;

  logic [pfdc_pkg::MUL_A_W-1:0]  mul_a;
  logic [pfdc_pkg::MUL_B_W-1:0]  mul_b;
  logic [pfdc_pkg::MUL_P_W-1:0]  mul_p;
  logic [pfdc_pkg::MUL_A_W-1:0]  prod_r;

  logic [pfdc_pkg::FREQ_W-1:0]   freq_r;
  logic [pfdc_pkg::CODE_W-1:0]   code_r;
  logic [pfdc_pkg::MV_W-1:0]     mv_r;
  logic [pfdc_pkg::CODE_W-1:0]   code_lo;
  logic [pfdc_pkg::CODE_W-1:0]   code_hi;
  logic [pfdc_pkg::CODE_W-1:0]   code_span;
  logic [6:0]                    f_off;
  logic                          in_range;
  logic                          out_free;
  logic [pfdc_pkg::PW_W-1:0]     width_out;
  logic                          pos;

  assign in_stall  = (state != ST_IDLE) || st_done;
  assign edge_ev   = in_valid && !in_stall && (in_beat.command == pfdc_pkg::CMD_EDGE);
  assign sample_ev = in_valid && !in_stall && (in_beat.command == pfdc_pkg::CMD_SAMPLE);
  assign out_free  = !out_valid || !out_stall;

  if (TIME_BITS > pfdc_pkg::TS_W) begin : g_ts_wide
    assign ts = TIME_BITS'(in_beat.timestamp_us);
  end else begin : g_ts_narrow
    assign ts = in_beat.timestamp_us[TIME_BITS-1:0];
  end

  if (TIME_BITS < pfdc_pkg::PW_W) begin : g_pw_narrow
    assign width_out = pfdc_pkg::PW_W'(width);
  end else begin : g_pw_wide
    assign width_out = width[pfdc_pkg::PW_W-1:0];
  end

  assign pos = (width != '0) && !width[TIME_BITS-1];

  pfdc_track #(.TIME_BITS(TIME_BITS)) u_track (
    .clk     (clk),
    .rst     (rst),
    .edge_ev (edge_ev),
    .ts      (ts),
    .falling (in_beat.edge_falling),
    .period  (period),
    .width   (width)
  );

  pfdc_div #(.TIME_BITS(TIME_BITS), .NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    code_lo   = mode ? '0 : pfdc_pkg::CODE_W'(pfdc_pkg::CODE_LO_N);
    code_hi   = mode ? pfdc_pkg::CODE_W'(pfdc_pkg::CODE_FULL)
                     : pfdc_pkg::CODE_W'(pfdc_pkg::CODE_HI_N);
    code_span = code_hi - code_lo;
    in_range  = (freq_r > pfdc_pkg::FREQ_W'(pfdc_pkg::F_LO)) &&
                (freq_r < pfdc_pkg::FREQ_W'(pfdc_pkg::F_HI));
    f_off     = 7'(freq_r - pfdc_pkg::FREQ_W'(pfdc_pkg::F_LO));
  end

  assign mul_p = pfdc_pkg::MUL_P_W'(mul_a) * pfdc_pkg::MUL_P_W'(mul_b);

  // divider and multiplier operand select, sequencer
  always_comb begin
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    mul_a      = '0;
    mul_b      = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_ev) begin
          div_start  = 1'b1;
          div_num    = NUM_W'(pfdc_pkg::FREQ_SCALE) + NUM_W'(period >> 1);
          div_den    = period;
          state_next = ST_FREQ;
        end
      end
      ST_FREQ: begin
        if (div_done) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        mul_a = pfdc_pkg::MUL_A_W'(f_off);
        mul_b = pfdc_pkg::MUL_B_W'(code_span);
        if (in_range) begin
          state_next = ST_CODE;
        end else begin
          state_next = ST_MVM;
        end
      end
      ST_CODE: begin
        mul_a      = prod_r;
        mul_b      = pfdc_pkg::MUL_B_W'(pfdc_pkg::RECIP_SPAN);
        state_next = ST_MVM;
      end
      ST_MVM: begin
        mul_a      = pfdc_pkg::MUL_A_W'(code_r);
        mul_b      = pfdc_pkg::MUL_B_W'(pfdc_pkg::MV_FULL);
        state_next = ST_MV;
      end
      ST_MV: begin
        mul_a      = prod_r;
        mul_b      = pfdc_pkg::MUL_B_W'(pfdc_pkg::RECIP_FULL);
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      st_done   <= 1'b0;
      mode      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        mode <= cfg_data;
      end
      // finished result waits here until the output register frees up
      if (state == ST_MV) begin
        st_done <= 1'b1;
      end else if (st_done && out_free) begin
        st_done <= 1'b0;
      end
      if (st_done && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FREQ && div_done) begin
      freq_r <= (period == '0) ? '0 : quo[pfdc_pkg::FREQ_W-1:0];
    end
    if (state == ST_MAP) begin
      if (in_range) begin
        prod_r <= mul_p[pfdc_pkg::MUL_A_W-1:0];
      end else begin
        code_r <= (freq_r <= pfdc_pkg::FREQ_W'(pfdc_pkg::F_LO)) ? code_lo : code_hi;
      end
    end
    if (state == ST_CODE) begin
      code_r <= mul_p[pfdc_pkg::SH_SPAN+pfdc_pkg::CODE_W-1:pfdc_pkg::SH_SPAN] + code_lo;
    end
    if (state == ST_MVM) begin
      prod_r <= mul_p[pfdc_pkg::MUL_A_W-1:0];
    end
    if (state == ST_MV) begin
      mv_r <= mul_p[pfdc_pkg::SH_FULL+pfdc_pkg::MV_W-1:pfdc_pkg::SH_FULL];
    end
    if (st_done && out_free) begin
      out_beat.frequency_hz      <= freq_r;
      out_beat.pulse_width_us    <= width_out;
      out_beat.dac_code          <= code_r;
      out_beat.output_millivolts <= mv_r;
      out_beat.sample_valid      <= pos && (period != '0);
    end
  end

endmodule
`default_nettype wire

### test/pulse_frequency_to_dac_code_tb.sv
// Self-checking testbench for pulse_frequency_to_dac_code: edge/sample beats in,
// readings checked against an in-bench mirror of the edge tracker and code map.
// Depends on rtl/pfdc_pkg.sv and rtl/pulse_frequency_to_dac_code.sv.
`timescale 1ns / 1ps
module pulse_frequency_to_dac_code_tb;

  localparam int SETTLE_CYCLES = 100;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic                cfg_data = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  pfdc_pkg::in_beat_t  in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pfdc_pkg::out_beat_t out_beat;

  pulse_frequency_to_dac_code dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  initial forever #5 clk = ~clk;

  // mirror of the block's register and edge tracker
  bit        mode_full = 1'b1;
  bit        armed_m, phase_m;
  bit [31:0] prev_rise_m, last_rise_m, mark_m, period_m;

  pfdc_pkg::out_beat_t pending_readings[$];
  bit        idle_on = 1'b1;
  int        mismatches, beats_sent, readings_seen;

  function automatic pfdc_pkg::out_beat_t convert_sample();
    pfdc_pkg::out_beat_t r;
    bit [31:0]           width;
    longint unsigned     p, freq, code, lo, hi;
    width = mark_m - last_rise_m;
    p     = 64'(period_m);
    freq  = 64'd0;
    if (p != 0) freq = (64'(pfdc_pkg::FREQ_SCALE) + p / 2) / p;
    lo = mode_full ? 64'd0 : 64'(pfdc_pkg::CODE_LO_N);
    hi = mode_full ? 64'(pfdc_pkg::CODE_FULL) : 64'(pfdc_pkg::CODE_HI_N);
    if (freq <= 64'(pfdc_pkg::F_LO)) code = lo;
    else if (freq >= 64'(pfdc_pkg::F_HI)) code = hi;
    else code = (freq - 64'(pfdc_pkg::F_LO)) * (hi - lo) / 64'(pfdc_pkg::F_SPAN) + lo;
    r.frequency_hz      = freq[pfdc_pkg::FREQ_W-1:0];
    r.pulse_width_us    = width;
    r.dac_code          = code[pfdc_pkg::CODE_W-1:0];
    r.output_millivolts =
      13'(code * 64'(pfdc_pkg::MV_FULL) / 64'(pfdc_pkg::CODE_FULL));
    r.sample_valid      = (width != 0) && !width[31] && (period_m != 0);
    return r;
  endfunction

  function automatic void track_beat(pfdc_pkg::in_beat_t b);
    if (b.command == pfdc_pkg::CMD_SAMPLE) begin
      pending_readings.push_back(convert_sample());
    end else if (!armed_m) begin
      if (b.edge_falling) armed_m = 1'b1;
    end else if (phase_m) begin
      phase_m     = 1'b0;
      prev_rise_m = last_rise_m;
      last_rise_m = b.timestamp_us;
      period_m    = last_rise_m - prev_rise_m;
    end else begin
      phase_m = 1'b1;
      mark_m  = b.timestamp_us;
    end
  endfunction

  function automatic pfdc_pkg::in_beat_t make_beat(logic cmd, logic [31:0] ts, logic fall);
    pfdc_pkg::in_beat_t b;
    b.command      = cmd;
    b.timestamp_us = ts;
    b.edge_falling = fall;
    return b;
  endfunction

  task automatic send_beat(pfdc_pkg::in_beat_t b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    track_beat(b);
    beats_sent++;
  endtask

  task automatic take_sample();
    send_beat(make_beat(pfdc_pkg::CMD_SAMPLE, $urandom, 1'($urandom_range(0, 1))));
  endtask

  task automatic send_edge(logic [31:0] ts, logic fall);
    send_beat(make_beat(pfdc_pkg::CMD_EDGE, ts, fall));
  endtask

  // one rise, then the mark, then a sample while the pulse is still open
  task automatic pulse_cycle(bit [31:0] period, bit [31:0] width);
    bit [31:0] rise_t;
    rise_t = last_rise_m + period;
    send_edge(rise_t, 1'b0);
    send_edge(rise_t + width, 1'b1);
    take_sample();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    mode_full = m;
  endtask

  // ---------------- result side ----------------
  int unsigned rx_hold;

  always @(posedge clk) begin
    if (out_valid === 1'b1 && !out_stall) rx_hold = idle_on ? $urandom_range(0, 4) : 0;
    else if (rx_hold != 0) rx_hold--;
    out_stall <= (rx_hold != 0);
  end

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
  endfunction

  always @(posedge clk) begin
    pfdc_pkg::out_beat_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_readings.size() == 0) begin
        note_failure($sformatf("reading with none pending: %p", out_beat));
      end else begin
        want = pending_readings.pop_front();
        readings_seen++;
        check_field("frequency_hz", 32'(want.frequency_hz),
                    32'(out_beat.frequency_hz));
        check_field("pulse_width_us", want.pulse_width_us, out_beat.pulse_width_us);
        check_field("dac_code", 32'(want.dac_code), 32'(out_beat.dac_code));
        check_field("output_millivolts", 32'(want.output_millivolts),
                    32'(out_beat.output_millivolts));
        check_field("sample_valid", 32'(want.sample_valid),
                    32'(out_beat.sample_valid));
      end
    end
  end

  // ---------------- tests ----------------
  // sample before arming reports the reset state; rises are ignored until a fall
  task automatic test_arming();
    take_sample();
    send_edge(32'h0000_1234, 1'b0);
    send_edge(32'h0000_5678, 1'b1);
    // first mark far ahead of the zero rise: width reads negative, period still zero
    send_edge(32'hFFFF_FFFF, 1'b1);
    take_sample();
  endtask

  task automatic test_map_full_range();
    pulse_cycle(32'd1, 32'd0);       // fastest period, zero width
    pulse_cycle(32'd20000, 32'd3000); // 50 Hz, lower clamp
    pulse_cycle(32'd6667, 32'd1500);  // rounds up to 150 Hz
    pulse_cycle(32'd0, 32'd700);      // zero period
  endtask

  task automatic test_map_narrow_range();
    set_mode(1'b0);
    pulse_cycle(32'd19608, 32'd9000); // 51 Hz
    pulse_cycle(32'd6711, 32'd2000);  // 149 Hz
    pulse_cycle(32'd10000, 32'd5000); // mid scale
    set_mode(1'b1);
  endtask

  function automatic bit [31:0] draw_period();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 65) return $urandom_range(5500, 22000);
    if (k < 75) return $urandom_range(0, 3);
    if (k < 82) return $urandom_range(6600, 6800);
    if (k < 89) return $urandom_range(19500, 20500);
    return $urandom;
  endfunction

  function automatic bit [31:0] draw_width();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 80) return $urandom_range(1, 4000);
    if (k < 88) return 32'd0;
    return $urandom;
  endfunction

  // mostly well-formed rise/mark/sample trains, with some stray beats mixed in
  task automatic run_pulse_train(int n_beats, bit pause_midway);
    int start;
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      if (pause_midway && beats_sent - start >= n_beats / 2) begin
        settle();
        pause_midway = 1'b0;
      end
      if ($urandom_range(0, 99) < 8) begin
        send_beat(make_beat(1'($urandom_range(0, 1)), $urandom,
                            1'($urandom_range(0, 1))));
      end else if (phase_m) begin
        send_edge(last_rise_m + draw_period(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0) take_sample();
      end else begin
        send_edge(last_rise_m + draw_width(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) < 7) take_sample();
      end
    end
  endtask

  task automatic test_random_trains();
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0]);
      idle_on = (ph != 2);
      run_pulse_train(325, ph == 1);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_arming();
    test_map_full_range();
    test_map_narrow_range();
    test_random_trains();
    settle();
    if (pending_readings.size() != 0)
      note_failure($sformatf("%0d readings never arrived", pending_readings.size()));
    $display("sent %0d beats, checked %0d readings in both DAC modes,", beats_sent,
             readings_seen);
    $display("with and without handshake gaps, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("pulse_frequency_to_dac_code_tb: done, clean");
    end else begin
      $display("pulse_frequency_to_dac_code_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting on the block");
    $display("pulse_frequency_to_dac_code_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/pfdc_pkg.sv
rtl/pfdc_div.sv
rtl/pfdc_track.sv
rtl/pulse_frequency_to_dac_code.sv
test/pulse_frequency_to_dac_code_tb.sv
